// ----- design/lts_pkg.sv -----
// Shared types and constants for the LRU tag store.
package lts_pkg;

  // Store geometry.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 17;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 4;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // Command codes.
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  // One stored entry as held in the entry memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Sequencer to compare unit.
  typedef struct packed {
    logic             clear;
    logic             chk_vld;
    logic [IDX_W-1:0] chk_idx;
  } scan_ctl_t;

  // Compare unit to sequencer.
  typedef struct packed {
    logic             match;
    logic [IDX_W-1:0] best_idx;
  } scan_stat_t;

endpackage

// ----- design/lts_if.sv -----
// Valid/ready channel interfaces for the request and result words.
interface lts_in_if;
  logic                         valid;
  logic                         ready;
  lts_pkg::cmd_t                cmd;
  logic [lts_pkg::KEY_W-1:0]    key;
  logic [lts_pkg::SIZE_W-1:0]   obj_size;

  modport source (output valid, cmd, key, obj_size, input ready);
  modport sink   (input valid, cmd, key, obj_size, output ready);
endinterface

interface lts_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lts_pkg::SLOT_W-1:0]   slot;
  logic [lts_pkg::SIZE_W-1:0]   stored_size;
  logic                         evicted;

  modport source (output valid, hit, slot, stored_size, evicted, input ready);
  modport sink   (input valid, hit, slot, stored_size, evicted, output ready);
endinterface

// ----- design/lru_tag_store_timestamp.sv -----
// An insert with a free entry or a lookup of an empty store goes straight to the
// result state; a lookup or an insert into a full store first scans the filled
// entries, and a lookup hit ends the scan early.
// The scan is paced by the single entry memory read port, one entry per cycle,
// and the next word is taken only after the result enters the output register.
// Synchronous active-low reset empties the store and zeroes the stamp counter.
module lru_tag_store_timestamp (
  input  logic      clk,
  input  logic      rst_n,
  lts_in_if.sink    in_ch,
  lts_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  lts_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [lts_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [lts_pkg::SIZE_W-1:0]    size_r, size_nxt;
  logic [lts_pkg::CNT_W-1:0]     fill_r, fill_nxt;
  logic [lts_pkg::STAMP_W-1:0]   stamp_ctr_r, stamp_ctr_nxt;
  logic [lts_pkg::CNT_W-1:0]     issue_idx_r, issue_idx_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [lts_pkg::IDX_W-1:0]     chk_idx_r, chk_idx_nxt;

  // Pending result, then the output register.
  logic                          res_hit_r, res_hit_nxt;
  logic [lts_pkg::SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic [lts_pkg::SIZE_W-1:0]    res_size_r, res_size_nxt;
  logic                          res_evicted_r, res_evicted_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [lts_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [lts_pkg::SIZE_W-1:0]    out_size_r, out_size_nxt;
  logic                          out_evicted_r, out_evicted_nxt;

  logic                          ram_we;
  logic [lts_pkg::IDX_W-1:0]     ram_waddr;
  lts_pkg::entry_t               ram_wdata;
  logic                          ram_re;
  logic [lts_pkg::IDX_W-1:0]     ram_raddr;
  lts_pkg::entry_t               ram_rdata;

  lts_pkg::scan_ctl_t            scan_ctl;
  lts_pkg::scan_stat_t           scan_stat;
  logic                          chk_last;
  logic                          in_acc;

  // Entry memory: key, size and stamp per entry.
  lts_ram #(
    .WIDTH ($bits(lts_pkg::entry_t)),
    .DEPTH (lts_pkg::ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Compare unit, fed one entry per cycle during a scan.
  lts_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .req_key (key_r),
    .ent     (ram_rdata),
    .stat    (scan_stat)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.stored_size = out_size_r;
  assign out_ch.evicted     = out_evicted_r;

  // The entry under compare is the last filled one.
  assign chk_last = chk_vld_r &&
                    ((lts_pkg::CNT_W'(chk_idx_r) + lts_pkg::CNT_W'(1)) == fill_r);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    size_nxt        = size_r;
    fill_nxt        = fill_r;
    stamp_ctr_nxt   = stamp_ctr_r;
    issue_idx_nxt   = issue_idx_r;
    chk_vld_nxt     = chk_vld_r;
    chk_idx_nxt     = chk_idx_r;
    res_hit_nxt     = res_hit_r;
    res_slot_nxt    = res_slot_r;
    res_size_nxt    = res_size_r;
    res_evicted_nxt = res_evicted_r;
    out_valid_nxt   = out_valid_r;
    out_hit_nxt     = out_hit_r;
    out_slot_nxt    = out_slot_r;
    out_size_nxt    = out_size_r;
    out_evicted_nxt = out_evicted_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = issue_idx_r[lts_pkg::IDX_W-1:0];
    scan_ctl.clear   = 1'b0;
    scan_ctl.chk_vld = chk_vld_r;
    scan_ctl.chk_idx = chk_idx_r;

    // The output register empties when the sink takes the word.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_ch.cmd;
          key_nxt  = in_ch.key;
          size_nxt = in_ch.obj_size;
          if (in_ch.cmd == lts_pkg::CMD_INSERT && fill_r != lts_pkg::FULL_CNT) begin
            // Free entry available: write it straight away.
            ram_we          = 1'b1;
            ram_waddr       = fill_r[lts_pkg::IDX_W-1:0];
            ram_wdata.key   = in_ch.key;
            ram_wdata.size  = in_ch.obj_size;
            ram_wdata.stamp = stamp_ctr_r;
            stamp_ctr_nxt   = stamp_ctr_r + lts_pkg::STAMP_W'(1);
            fill_nxt        = fill_r + lts_pkg::CNT_W'(1);
            res_hit_nxt     = 1'b0;
            res_slot_nxt    = lts_pkg::SLOT_W'(fill_r[lts_pkg::IDX_W-1:0]);
            res_size_nxt    = in_ch.obj_size;
            res_evicted_nxt = 1'b0;
            state_nxt       = S_DONE;
          end else if (in_ch.cmd == lts_pkg::CMD_LOOKUP && fill_r == '0) begin
            // Lookup of an empty store misses at once.
            res_hit_nxt     = 1'b0;
            res_slot_nxt    = '0;
            res_size_nxt    = '0;
            res_evicted_nxt = 1'b0;
            state_nxt       = S_DONE;
          end else begin
            issue_idx_nxt  = '0;
            chk_vld_nxt    = 1'b0;
            scan_ctl.clear = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle over the filled entries.
        if (issue_idx_r < fill_r) begin
          ram_re        = 1'b1;
          issue_idx_nxt = issue_idx_r + lts_pkg::CNT_W'(1);
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = issue_idx_r[lts_pkg::IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end

        // Judge the entry whose data has just come back.
        if (chk_vld_r) begin
          if (cmd_r == lts_pkg::CMD_LOOKUP && scan_stat.match) begin
            ram_we          = 1'b1;
            ram_waddr       = chk_idx_r;
            ram_wdata.key   = ram_rdata.key;
            ram_wdata.size  = ram_rdata.size;
            ram_wdata.stamp = stamp_ctr_r;
            stamp_ctr_nxt   = stamp_ctr_r + lts_pkg::STAMP_W'(1);
            res_hit_nxt     = 1'b1;
            res_slot_nxt    = lts_pkg::SLOT_W'(chk_idx_r);
            res_size_nxt    = ram_rdata.size;
            res_evicted_nxt = 1'b0;
            chk_vld_nxt     = 1'b0;
            state_nxt       = S_DONE;
          end else if (chk_last) begin
            if (cmd_r == lts_pkg::CMD_LOOKUP) begin
              res_hit_nxt     = 1'b0;
              res_slot_nxt    = '0;
              res_size_nxt    = '0;
              res_evicted_nxt = 1'b0;
            end else begin
              // Store full: replace the oldest entry.
              ram_we          = 1'b1;
              ram_waddr       = scan_stat.best_idx;
              ram_wdata.key   = key_r;
              ram_wdata.size  = size_r;
              ram_wdata.stamp = stamp_ctr_r;
              stamp_ctr_nxt   = stamp_ctr_r + lts_pkg::STAMP_W'(1);
              res_hit_nxt     = 1'b0;
              res_slot_nxt    = lts_pkg::SLOT_W'(scan_stat.best_idx);
              res_size_nxt    = size_r;
              res_evicted_nxt = 1'b1;
            end
            chk_vld_nxt = 1'b0;
            state_nxt   = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = res_hit_r;
          out_slot_nxt    = res_slot_r;
          out_size_nxt    = res_size_r;
          out_evicted_nxt = res_evicted_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      stamp_ctr_r <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      stamp_ctr_r <= stamp_ctr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    size_r        <= size_nxt;
    issue_idx_r   <= issue_idx_nxt;
    chk_idx_r     <= chk_idx_nxt;
    res_hit_r     <= res_hit_nxt;
    res_slot_r    <= res_slot_nxt;
    res_size_r    <= res_size_nxt;
    res_evicted_r <= res_evicted_nxt;
    out_hit_r     <= out_hit_nxt;
    out_slot_r    <= out_slot_nxt;
    out_size_r    <= out_size_nxt;
    out_evicted_r <= out_evicted_nxt;
  end

`ifndef SYNTHESIS
  // The fill count never passes the store depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lts_pkg::FULL_CNT)
    else $error("fill count beyond store depth");

  // The stamp counter only ever steps by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(stamp_ctr_r) |->
      stamp_ctr_r == $past(stamp_ctr_r) + lts_pkg::STAMP_W'(1))
    else $error("stamp counter jumped");

  // An eviction can only come from a full store.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && res_evicted_r |-> fill_r == lts_pkg::FULL_CNT)
    else $error("eviction with free entries");

  // Compare data is only judged during a scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> state_r == S_SCAN)
    else $error("compare valid outside a scan");

  // A hit never reports an eviction.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_evicted_r)
    else $error("hit word flags an eviction");
`endif

endmodule

// ----- design/lts_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- design/lts_scan.sv -----
// Shared compare unit: key match and running oldest-stamp search over a scan.
module lts_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lts_pkg::scan_ctl_t           ctl,
  input  logic [lts_pkg::KEY_W-1:0]    req_key,
  input  lts_pkg::entry_t              ent,
  output lts_pkg::scan_stat_t          stat
);

  logic                        has_best_r;
  logic [lts_pkg::IDX_W-1:0]   best_idx_r;
  logic [lts_pkg::STAMP_W-1:0] best_stamp_r;
  logic                        take_cur;

  // A strictly smaller stamp wins, so ties keep the lower index.
  assign take_cur = !has_best_r || (ent.stamp < best_stamp_r);

  assign stat.match    = (ent.key == req_key);
  assign stat.best_idx = take_cur ? ctl.chk_idx : best_idx_r;

  // Track the oldest entry seen so far in this scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_best_r <= 1'b0;
    end else if (ctl.clear) begin
      has_best_r <= 1'b0;
    end else if (ctl.chk_vld) begin
      has_best_r <= 1'b1;
      if (take_cur) begin
        best_idx_r   <= ctl.chk_idx;
        best_stamp_r <= ent.stamp;
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the LRU tag store: lookup and insert words in, results checked.
module tb_top;

  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Receiver back-pressure stretch used to fill the block and stall its input.
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_WORDS = 1375;
  localparam int KEY_POOL = 20;

  typedef struct packed {
    lts_pkg::cmd_t              cmd;
    logic [lts_pkg::KEY_W-1:0]  key;
    logic [lts_pkg::SIZE_W-1:0] obj_size;
  } req_word_t;

  typedef struct packed {
    logic                       hit;
    logic [lts_pkg::SLOT_W-1:0] slot;
    logic [lts_pkg::SIZE_W-1:0] stored_size;
    logic                       evicted;
  } rsp_word_t;

  logic clk;
  logic rst_n;

  lts_in_if  in_ch ();
  lts_out_if out_ch ();

  lru_tag_store_timestamp DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Words waiting to be offered, and results predicted for accepted words.
  req_word_t pending_words[$];
  rsp_word_t expected_results[$];

  // Shadow copy of the tag store.
  logic [lts_pkg::KEY_W-1:0]   shadow_keys   [lts_pkg::ENTRIES];
  logic [lts_pkg::SIZE_W-1:0]  shadow_sizes  [lts_pkg::ENTRIES];
  logic [lts_pkg::STAMP_W-1:0] shadow_stamps [lts_pkg::ENTRIES];
  int                          fill_level = 0;
  logic [lts_pkg::STAMP_W-1:0] stamp_clock = '0;

  logic [lts_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  int n_words;
  int words_accepted = 0;
  int stall_cycles = 0;
  int fail_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one word to the shadow store and returns the result it should produce.
  function automatic rsp_word_t store_update(req_word_t w);
    rsp_word_t r;
    int        victim;
    bit        found;
    r = '0;
    found = 1'b0;
    if (w.cmd == lts_pkg::CMD_LOOKUP) begin
      // The lowest-index filled copy of the key wins; a miss leaves the clock alone.
      for (int i = 0; i < fill_level; i++) begin
        if (!found && shadow_keys[i] == w.key) begin
          found = 1'b1;
          shadow_stamps[i] = stamp_clock;
          stamp_clock = stamp_clock + 1'b1;
          r.hit = 1'b1;
          r.slot = lts_pkg::SLOT_W'(i);
          r.stored_size = shadow_sizes[i];
        end
      end
    end else begin
      if (fill_level < lts_pkg::ENTRIES) begin
        victim = fill_level;
        fill_level = fill_level + 1;
      end else begin
        // Oldest stamp by plain unsigned compare, lowest index on ties.
        victim = 0;
        for (int i = 1; i < lts_pkg::ENTRIES; i++) begin
          if (shadow_stamps[i] < shadow_stamps[victim]) victim = i;
        end
        r.evicted = 1'b1;
      end
      shadow_keys[victim] = w.key;
      shadow_sizes[victim] = w.obj_size;
      shadow_stamps[victim] = stamp_clock;
      stamp_clock = stamp_clock + 1'b1;
      r.slot = lts_pkg::SLOT_W'(victim);
      r.stored_size = w.obj_size;
    end
    return r;
  endfunction

  // Idle pattern: sender light and receiver heavy, then swapped, then none.
  function automatic int idle_phase();
    if (words_accepted < n_words / 3) return 0;
    if (words_accepted < (2 * n_words) / 3) return 1;
    return 2;
  endfunction

  function automatic logic [lts_pkg::KEY_W-1:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_word(lts_pkg::cmd_t cmd, logic [lts_pkg::KEY_W-1:0] key,
                            logic [lts_pkg::SIZE_W-1:0] size);
    req_word_t w;
    w.cmd = cmd;
    w.key = key;
    w.obj_size = size;
    pending_words.push_back(w);
  endtask

  // Driver: records accepted words and offers the next pending one.
  always @(posedge clk) begin : drive_proc
    req_word_t next_word;
    req_word_t taken;
    bit        pause;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= lts_pkg::CMD_LOOKUP;
      in_ch.key <= '0;
      in_ch.obj_size <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.cmd = in_ch.cmd;
        taken.key = in_ch.key;
        taken.obj_size = in_ch.obj_size;
        expected_results.push_back(store_update(taken));
        words_accepted <= words_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        case (idle_phase())
          0: pause = ($urandom_range(99) < 12);
          1: pause = ($urandom_range(99) < 66);
          default: pause = 1'b0;
        endcase
        if (pending_words.size() != 0 && !pause) begin
          next_word = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= next_word.cmd;
          in_ch.key <= next_word.key;
          in_ch.obj_size <= next_word.obj_size;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with one long hold-off once idling has stopped.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_phase() == 2 && !hold_done &&
                 words_accepted >= (2 * n_words) / 3 + 50) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      case (idle_phase())
        0: out_ch.ready <= ($urandom_range(99) >= 66);
        1: out_ch.ready <= ($urandom_range(99) >= 12);
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk) begin : check_proc
    rsp_word_t exp_r;
    int        errs;
    errs = 0;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation pending");
        errs = errs + 1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.hit !== exp_r.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", exp_r.hit, out_ch.hit);
          errs = errs + 1;
        end
        if (out_ch.slot !== exp_r.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", exp_r.slot, out_ch.slot);
          errs = errs + 1;
        end
        if (out_ch.stored_size !== exp_r.stored_size) begin
          $error("stored_size mismatch: expected %0d, actual %0d",
                 exp_r.stored_size, out_ch.stored_size);
          errs = errs + 1;
        end
        if (out_ch.evicted !== exp_r.evicted) begin
          $error("evicted mismatch: expected %0d, actual %0d",
                 exp_r.evicted, out_ch.evicted);
          errs = errs + 1;
        end
      end
    end
    if (errs != 0)
      fail_count <= fail_count + errs;
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    rst_n = 1'b0;

    // Directed part: empty-store miss, extreme keys and sizes, duplicate keys,
    // filling the store, then evictions and a lookup of an evicted key.
    queue_word(lts_pkg::CMD_LOOKUP, '0, '0);
    queue_word(lts_pkg::CMD_INSERT, '0, '0);
    queue_word(lts_pkg::CMD_INSERT, '1, '1);
    queue_word(lts_pkg::CMD_INSERT, '1, lts_pkg::SIZE_W'(5));
    queue_word(lts_pkg::CMD_LOOKUP, '1, '1);
    queue_word(lts_pkg::CMD_LOOKUP, '0, '1);
    queue_word(lts_pkg::CMD_LOOKUP, 64'h0123_4567_89ab_cdef, '0);
    for (int i = 3; i < lts_pkg::ENTRIES; i++)
      queue_word(lts_pkg::CMD_INSERT, random_key(), lts_pkg::SIZE_W'($urandom()));
    queue_word(lts_pkg::CMD_INSERT, 64'h5555_aaaa_5555_aaaa, '1);
    queue_word(lts_pkg::CMD_INSERT, 64'haaaa_5555_aaaa_5555, lts_pkg::SIZE_W'(1));
    queue_word(lts_pkg::CMD_LOOKUP, '1, '0);
    queue_word(lts_pkg::CMD_LOOKUP, '0, '0);
    queue_word(lts_pkg::CMD_INSERT, 64'h8000_0000_0000_0001, lts_pkg::SIZE_W'(65536));

    // Random part: mostly keys from a small pool so hits, duplicates and
    // evictions are common, with some fresh keys as noise.
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = random_key();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(99) < 85)
        queue_word(($urandom_range(99) < 60) ? lts_pkg::CMD_LOOKUP : lts_pkg::CMD_INSERT,
                   key_pool[$urandom_range(KEY_POOL - 1)], lts_pkg::SIZE_W'($urandom()));
      else
        queue_word(($urandom_range(1) == 0) ? lts_pkg::CMD_LOOKUP : lts_pkg::CMD_INSERT,
                   random_key(), lts_pkg::SIZE_W'($urandom()));
    end
    n_words = pending_words.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Run until every word is in and every result is out, or the block hangs.
    while ((pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0 ||
            words_accepted != n_words) && stall_cycles < STALL_LIMIT)
      @(posedge clk);

    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
    end else begin
      // Drain: catch any stray result after the last expected one.
      repeat (2 * lts_pkg::ENTRIES + 8) @(posedge clk);
      if (fail_count == 0 && expected_results.size() == 0)
        $display("simulation ok");
      else
        $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lts_pkg.sv
design/lts_if.sv
design/lts_ram.sv
design/lts_scan.sv
design/lru_tag_store_timestamp.sv
test/tb_top.sv
